// ===== design/proportional_glyph_row_renderer_unit_defines.svh =====
// Assertion macros shared by the glyph row renderer RTL.
// The macros expect signals named clock and reset in the including module.
`ifndef PROPORTIONAL_GLYPH_ROW_RENDERER_UNIT_DEFINES_SVH
`define PROPORTIONAL_GLYPH_ROW_RENDERER_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PGRR_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked out of reset.
`define PGRR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/pgrr_pkg.sv =====
// Package for the glyph row renderer: command codes, register indexes,
// register reset values and the request and response beat types. No dependencies.
`timescale 1ns / 1ps

package pgrr_pkg;

   typedef enum logic [1:0] {
      CMD_LOAD_ROW   = 2'd0,
      CMD_LOAD_WIDTH = 2'd1,
      CMD_DRAW       = 2'd2
   } cmd_type;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 5;

   localparam logic [CSR_INDEX_W-1:0] CSR_GLYPH_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GLYPH_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHAR_SPACING = 2'd2;

   localparam logic [4:0] GLYPH_WIDTH_RESET  = 5'd8;
   localparam logic [4:0] GLYPH_HEIGHT_RESET = 5'd8;
   localparam logic [3:0] CHAR_SPACING_RESET = 4'd1;

   typedef struct packed {
      cmd_type     cmd;
      logic [7:0]  char_code;
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic [3:0]  row_index;
      logic [15:0] row_bits;
      logic [4:0]  width_value;
      logic [15:0] fg_color;
      logic [15:0] bg_color;
      logic        bg_transparent;
   } req_type;

   typedef struct packed {
      logic [15:0] row_y;
      logic [15:0] x_start;
      logic [15:0] ink_mask;
      logic [4:0]  glyph_cols;
      logic [3:0]  fill_cols;
      logic [15:0] ink_color;
      logic [15:0] back_color;
      logic        back_fill;
      logic [15:0] next_x;
      logic        last_row;
   } rsp_type;

endpackage

// ===== design/proportional_glyph_row_renderer_unit.sv =====
// Bitmap-font glyph row renderer: glyph row store, width store and row sequencer.
// Depends on pgrr_pkg and proportional_glyph_row_renderer_unit_defines.svh.
`timescale 1ns / 1ps
`include "proportional_glyph_row_renderer_unit_defines.svh"

// Usage
// A command beat on req_data is taken at a clock edge where start is high and
// busy is low. Load-row and load-width beats write the glyph store in that
// cycle, produce no response and leave busy low, so a new beat may follow in
// the next cycle. A draw beat produces one span per glyph row on rsp_data,
// each shown for exactly one cycle with rsp_valid high, top row first, with
// last_row set on the final span. The first span appears once the draw has passed
// the state register (ST_RUN) and then the read registers (rd_valid_ff, row_q_ff);
// the rows follow back to back, one row per cycle through the single read port of
// the row memory, and busy drops the cycle after the last span.
// A draw with zero effective height produces nothing and leaves busy low.
// The receiver cannot stall; spans must be taken when shown.
// The csr_ port writes glyph_width, glyph_height and char_spacing; write it
// only while busy is low. Reset restores the register defaults and idles the
// sequencer; the glyph stores are not cleared and must be loaded before use.
module proportional_glyph_row_renderer_unit
   import pgrr_pkg::*;
#(
   parameter int NUM_GLYPHS       = 256,
   parameter int MAX_GLYPH_WIDTH  = 16,
   parameter int MAX_GLYPH_HEIGHT = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  req_type                req_data,
   output logic                   rsp_valid,
   output rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CODE_W     = (NUM_GLYPHS > 1) ? $clog2(NUM_GLYPHS) : 1;
   localparam int ROW_DEPTH  = NUM_GLYPHS * MAX_GLYPH_HEIGHT;
   localparam int ADDR_W     = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1;
   localparam int WIDTH_CAP  = (MAX_GLYPH_WIDTH < 16) ? MAX_GLYPH_WIDTH : 16;
   localparam int HEIGHT_CAP = (MAX_GLYPH_HEIGHT < 16) ? MAX_GLYPH_HEIGHT : 16;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   // Configuration registers.
   logic [4:0] glyph_width_ff;
   logic [4:0] glyph_height_ff;
   logic [3:0] char_spacing_ff;

   // Sequencer state.
   state_type  state_ff, state_in;
   logic [3:0] issue_row_ff, issue_row_in;
   logic       rd_valid_ff, rd_valid_in;
   logic [3:0] rd_row_ff, rd_row_in;
   logic       rd_last_ff, rd_last_in;

   // Draw context, captured when a draw is taken.
   logic [CODE_W-1:0] code_ff;
   logic [ADDR_W-1:0] base_ff;
   logic [3:0]        last_idx_ff;
   logic [15:0]       pos_x_ff;
   logic [15:0]       pos_y_ff;
   logic [15:0]       fg_ff;
   logic [15:0]       bg_ff;
   logic              transp_ff;

   // Glyph stores.
   logic [15:0] row_mem [ROW_DEPTH];
   logic [4:0]  width_mem [NUM_GLYPHS];
   logic [15:0] row_q_ff;
   logic [4:0]  width_q_ff;

   logic [CODE_W-1:0] code_map [256];
   logic [CODE_W-1:0] code_mod;
   logic              accept;
   logic              draw_go;
   logic [4:0]        eff_width;
   logic [4:0]        eff_height;
   logic              row_we;
   logic              width_we;
   logic [ADDR_W-1:0] row_waddr;
   logic [ADDR_W-1:0] row_raddr;
   logic [ADDR_W-1:0] base_in;
   logic [4:0]        cols;
   logic [16:0]       mask_wide;

   // Character code folded into the store range; a constant table per code.
   for (genvar g = 0; g < 256; g++) begin : g_code_map
      assign code_map[g] = CODE_W'(g % NUM_GLYPHS);
   end
   assign code_mod = code_map[req_data.char_code];

   assign eff_width  = (glyph_width_ff > 5'(WIDTH_CAP)) ? 5'(WIDTH_CAP) : glyph_width_ff;
   assign eff_height = (glyph_height_ff > 5'(HEIGHT_CAP)) ? 5'(HEIGHT_CAP) : glyph_height_ff;

   assign busy    = (state_ff == ST_RUN) || rd_valid_ff;
   assign accept  = start && !busy;
   assign draw_go = accept && (req_data.cmd == CMD_DRAW) && (eff_height != 5'd0);

   assign row_we   = accept && (req_data.cmd == CMD_LOAD_ROW)
                     && (int'(req_data.row_index) < MAX_GLYPH_HEIGHT);
   assign width_we = accept && (req_data.cmd == CMD_LOAD_WIDTH);

   assign base_in   = ADDR_W'(int'(code_mod) * MAX_GLYPH_HEIGHT);
   assign row_waddr = ADDR_W'(int'(code_mod) * MAX_GLYPH_HEIGHT + int'(req_data.row_index));
   assign row_raddr = base_ff + ADDR_W'(issue_row_ff);

   always_comb begin
      state_in     = state_ff;
      issue_row_in = issue_row_ff;
      rd_valid_in  = 1'b0;
      rd_row_in    = issue_row_ff;
      rd_last_in   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (draw_go) begin
               state_in     = ST_RUN;
               issue_row_in = 4'd0;
            end
         end
         ST_RUN: begin
            // One row address goes to the memory each cycle.
            rd_valid_in = 1'b1;
            rd_last_in  = (issue_row_ff == last_idx_ff);
            if (issue_row_ff == last_idx_ff) begin
               state_in = ST_IDLE;
            end else begin
               issue_row_in = issue_row_ff + 4'd1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         issue_row_ff    <= 4'd0;
         rd_valid_ff     <= 1'b0;
         rd_row_ff       <= 4'd0;
         rd_last_ff      <= 1'b0;
         glyph_width_ff  <= GLYPH_WIDTH_RESET;
         glyph_height_ff <= GLYPH_HEIGHT_RESET;
         char_spacing_ff <= CHAR_SPACING_RESET;
      end else begin
         state_ff     <= state_in;
         issue_row_ff <= issue_row_in;
         rd_valid_ff  <= rd_valid_in;
         rd_row_ff    <= rd_row_in;
         rd_last_ff   <= rd_last_in;
         if (csr_we) begin
            case (csr_index)
               CSR_GLYPH_WIDTH:  glyph_width_ff  <= csr_wdata;
               CSR_GLYPH_HEIGHT: glyph_height_ff <= csr_wdata;
               CSR_CHAR_SPACING: char_spacing_ff <= csr_wdata[3:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (draw_go) begin
         code_ff     <= code_mod;
         base_ff     <= base_in;
         last_idx_ff <= 4'(eff_height - 5'd1);
         pos_x_ff    <= req_data.pos_x;
         pos_y_ff    <= req_data.pos_y;
         fg_ff       <= req_data.fg_color;
         bg_ff       <= req_data.bg_color;
         transp_ff   <= req_data.bg_transparent;
      end
   end

   // No access overlap: loads and reads never share a cycle since loads wait on busy.
   always_ff @(posedge clock) begin
      if (row_we) begin
         row_mem[row_waddr] <= req_data.row_bits;
      end
      row_q_ff <= row_mem[row_raddr];
   end

   always_ff @(posedge clock) begin
      if (width_we) begin
         width_mem[code_mod] <= req_data.width_value;
      end
      width_q_ff <= width_mem[code_ff];
   end

   assign cols      = (width_q_ff > eff_width) ? eff_width : width_q_ff;
   assign mask_wide = (17'd1 << cols) - 17'd1;

   assign rsp_valid           = rd_valid_ff;
   assign rsp_data.row_y      = pos_y_ff + 16'(rd_row_ff);
   assign rsp_data.x_start    = pos_x_ff;
   assign rsp_data.ink_mask   = row_q_ff & mask_wide[15:0];
   assign rsp_data.glyph_cols = cols;
   assign rsp_data.fill_cols  = transp_ff ? 4'd0 : char_spacing_ff;
   assign rsp_data.ink_color  = fg_ff;
   assign rsp_data.back_color = bg_ff;
   assign rsp_data.back_fill  = !transp_ff;
   assign rsp_data.next_x     = pos_x_ff + 16'(cols) + 16'(char_spacing_ff);
   assign rsp_data.last_row   = rd_last_ff;

   `PGRR_ASSERT_SAME(a_rsp_while_busy, rsp_valid, busy, "span beat outside a draw")
   `PGRR_ASSERT_NEXT(a_draw_starts, draw_go, state_ff == ST_RUN, "draw did not start")
   `PGRR_ASSERT_NEXT(a_last_ends, rsp_valid && rsp_data.last_row, !rsp_valid,
                     "span beat after the last row")
   `PGRR_ASSERT_NEXT(a_rows_contiguous, rsp_valid && !rsp_data.last_row,
                     rsp_valid && (rsp_data.row_y == $past(rsp_data.row_y) + 16'd1),
                     "row spans not consecutive")
   `PGRR_ASSERT_SAME(a_no_load_in_draw, row_we || width_we, state_ff == ST_IDLE,
                     "glyph store written during a draw")

endmodule
